>>> rtl/core/lens_distortion_coordinate_map_top_assert.svh
// assertion macros used by the lens distortion map checker
`ifndef LENS_DISTORTION_COORDINATE_MAP_TOP_ASSERT_SVH
`define LENS_DISTORTION_COORDINATE_MAP_TOP_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define LDCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, skipped while reset is high
`define LDCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches reset itself
`define LDCM_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ldcm_pkg.sv
// package: shared types, constants and saturation helper for the lens distortion map
`default_nettype none
package ldcm_pkg;

  // fixed-point formats
  localparam int unsigned CoordFracBits = 24;
  localparam int unsigned CoefFracBits  = 30;
  localparam int unsigned PitchFracBits = 31;
  localparam int unsigned InvFracBits   = 16;
  localparam int unsigned MaxDimension  = 4096;

  // intermediate value and accumulator widths
  localparam int unsigned ValW = 48;
  localparam int unsigned AccW = ValW + 3;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AccW-1:0] acc_t;

  localparam val_t ValLim = {1'b0, {(ValW-1){1'b1}}};

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_RADIAL_A1_A2          = 4'd0,
    REG_RADIAL_A3_ZERO_RADIUS = 4'd1,
    REG_DECENTERING_B1_B2     = 4'd2,
    REG_AFFINE_C1_C2          = 4'd3,
    REG_PRINCIPAL_SHIFT       = 4'd4,
    REG_PIXEL_PITCH           = 4'd5,
    REG_INVERSE_PITCH         = 4'd6,
    REG_IMAGE_SIZE_MODE       = 4'd7
  } reg_idx_t;

  // clamp a sum to +-(2^47 - 1)
  function automatic val_t sat_val(acc_t v);
    val_t r;
    if (v > acc_t'(ValLim)) r = ValLim;
    else if (v < -acc_t'(ValLim)) r = -ValLim;
    else r = v[ValW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ldcm_mul.sv
// three-stage signed multiply, round half away from zero, shift and saturate
`default_nettype none
module ldcm_mul #(
  parameter int unsigned SHIFT = ldcm_pkg::CoordFracBits
) (
  input  wire             clk,
  input  wire             en,
  input  wire ldcm_pkg::val_t a,
  input  wire ldcm_pkg::val_t b,
  output ldcm_pkg::val_t  p
);

  localparam int unsigned W     = ldcm_pkg::ValW;
  localparam int unsigned HalfW = W / 2;
  localparam int unsigned ProdW = 2 * W;

  logic [W-1:0]     a_mag;
  logic [W-1:0]     b_mag;
  logic             neg1;
  logic [W-1:0]     pp_ll;
  logic [W-1:0]     pp_lh;
  logic [W-1:0]     pp_hl;
  logic [W-1:0]     pp_hh;
  logic             neg2;
  logic [ProdW-1:0] sum2;
  logic [ProdW-1:0] quo;
  logic [W-1:0]     mag3;

  // magnitudes of the operands
  always_comb begin
    a_mag = a[W-1] ? (~a + 1'b1) : a;
    b_mag = b[W-1] ? (~b + 1'b1) : b;
  end

  // stage 1: four half-width partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= a[W-1] ^ b[W-1];
      pp_ll <= a_mag[HalfW-1:0] * b_mag[HalfW-1:0];
      pp_lh <= a_mag[HalfW-1:0] * b_mag[W-1:HalfW];
      pp_hl <= a_mag[W-1:HalfW] * b_mag[HalfW-1:0];
      pp_hh <= a_mag[W-1:HalfW] * b_mag[W-1:HalfW];
    end
  end

  // stage 2: full product plus rounding half
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      sum2 <= ProdW'(pp_ll) + (ProdW'(pp_lh) << HalfW) + (ProdW'(pp_hl) << HalfW)
            + (ProdW'(pp_hh) << W) + (ProdW'(1) << (SHIFT - 1));
    end
  end

  // stage 3: shift, saturate, restore sign
  always_comb begin
    quo  = sum2 >> SHIFT;
    mag3 = (|quo[ProdW-1:W-1]) ? W'(ldcm_pkg::ValLim) : {1'b0, quo[W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg2 ? (~mag3 + 1'b1) : mag3;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lens_distortion_coordinate_map_top.sv
// top level: lens distortion coordinate map pipeline
// Maps a rectified pixel (pixel_x, pixel_y) to the source pixel of the
// distorted image through a radial, decentering and affine lens model.
// Input word on s_tdata, result word on m_tdata, both with tvalid/tready.
// Registers are written on the cfg port (cfg_we, cfg_index, cfg_data) while
// no word is in flight, a rule for the user that the block does not enforce;
// an index beyond the register list is ignored. Throughput: one word per
// cycle unless the output stalls; each ldcm_mul is a three-stage 48x48
// unit built from 24x24 partial products, and sums have one stage each.
// Terms that depend only on registers (R0 powers, image centre) run in free
// units and are settled well before the first word reaches them.
// Reset clears all registers to zero and empties the pipeline.
// When the receiver holds m_tready low with a word waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// s_tready is high whenever the output register is empty or being taken.
`default_nettype none
module lens_distortion_coordinate_map_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // pixel_x [11:0], pixel_y [23:12]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // source_x [15:0], source_y [31:16]
  input  wire         cfg_we,
  input  wire  [3:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  localparam int unsigned F        = ldcm_pkg::CoordFracBits;
  localparam int unsigned C        = ldcm_pkg::CoefFracBits;
  localparam int unsigned PixShift = ldcm_pkg::PitchFracBits - F;
  localparam int unsigned RndShift = F + ldcm_pkg::InvFracBits;
  localparam int unsigned W        = ldcm_pkg::ValW;
  localparam int unsigned RndW     = W + 32;
  localparam int unsigned LastSt   = 30;

  typedef ldcm_pkg::val_t val_t;
  typedef ldcm_pkg::acc_t acc_t;

  // configuration registers
  logic [63:0] radial_a1_a2;
  logic [63:0] radial_a3_zero_radius;
  logic [63:0] decentering_b1_b2;
  logic [63:0] affine_c1_c2;
  logic [63:0] principal_shift;
  logic [63:0] pixel_pitch;
  logic [63:0] inverse_pitch;
  logic [32:0] image_size_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      radial_a1_a2          <= '0;
      radial_a3_zero_radius <= '0;
      decentering_b1_b2     <= '0;
      affine_c1_c2          <= '0;
      principal_shift       <= '0;
      pixel_pitch           <= '0;
      inverse_pitch         <= '0;
      image_size_mode       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ldcm_pkg::REG_RADIAL_A1_A2:          radial_a1_a2          <= cfg_data;
        ldcm_pkg::REG_RADIAL_A3_ZERO_RADIUS: radial_a3_zero_radius <= cfg_data;
        ldcm_pkg::REG_DECENTERING_B1_B2:     decentering_b1_b2     <= cfg_data;
        ldcm_pkg::REG_AFFINE_C1_C2:          affine_c1_c2          <= cfg_data;
        ldcm_pkg::REG_PRINCIPAL_SHIFT:       principal_shift       <= cfg_data;
        ldcm_pkg::REG_PIXEL_PITCH:           pixel_pitch           <= cfg_data;
        ldcm_pkg::REG_INVERSE_PITCH:         inverse_pitch         <= cfg_data;
        ldcm_pkg::REG_IMAGE_SIZE_MODE:       image_size_mode       <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

  // register fields
  val_t a1, a2, a3, r0, b1, b2, c1, c2, dx, dy, px, py;
  logic [16:0] w_c;
  logic [16:0] h_c;
  logic        shift_mode;
  val_t        w_v, h_v;

  assign a1 = val_t'($signed(radial_a1_a2[31:0]));
  assign a2 = val_t'($signed(radial_a1_a2[63:32]));
  assign a3 = val_t'($signed(radial_a3_zero_radius[31:0]));
  assign r0 = val_t'($signed(radial_a3_zero_radius[63:32]));
  assign b1 = val_t'($signed(decentering_b1_b2[31:0]));
  assign b2 = val_t'($signed(decentering_b1_b2[63:32]));
  assign c1 = val_t'($signed(affine_c1_c2[31:0]));
  assign c2 = val_t'($signed(affine_c1_c2[63:32]));
  assign dx = val_t'($signed(principal_shift[31:0]));
  assign dy = val_t'($signed(principal_shift[63:32]));
  assign px = $signed({16'b0, pixel_pitch[31:0]});
  assign py = $signed({16'b0, pixel_pitch[63:32]});
  assign shift_mode = image_size_mode[32];

  // clamp image size to the largest supported dimension
  always_comb begin
    w_c = ({1'b0, image_size_mode[15:0]} > 17'(ldcm_pkg::MaxDimension))
          ? 17'(ldcm_pkg::MaxDimension) : {1'b0, image_size_mode[15:0]};
    h_c = ({1'b0, image_size_mode[31:16]} > 17'(ldcm_pkg::MaxDimension))
          ? 17'(ldcm_pkg::MaxDimension) : {1'b0, image_size_mode[31:16]};
    w_v = $signed({31'b0, w_c});
    h_v = $signed({31'b0, h_c});
  end

  // pipeline control
  logic vld [0:LastSt];
  logic adv;

  assign adv      = !vld[LastSt] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LastSt];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LastSt; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= LastSt; k++) vld[k] <= vld[k-1];
    end
  end

  // terms that depend on registers only
  val_t q2, q4, q6, x0, y0;

  ldcm_mul #(.SHIFT(F)) u_q2 (.clk, .en(1'b1), .a(r0), .b(r0), .p(q2));
  ldcm_mul #(.SHIFT(F)) u_q4 (.clk, .en(1'b1), .a(q2), .b(q2), .p(q4));
  ldcm_mul #(.SHIFT(F)) u_q6 (.clk, .en(1'b1), .a(q4), .b(q2), .p(q6));
  ldcm_mul #(.SHIFT(PixShift)) u_x0 (.clk, .en(1'b1), .a(px), .b(w_v), .p(x0));
  ldcm_mul #(.SHIFT(PixShift)) u_y0 (.clk, .en(1'b1), .a(py), .b(h_v), .p(y0));

  // stage registers and delay lines
  val_t tx0, ty0;
  val_t xp [4:24];
  val_t yp [4:24];
  val_t xx8, yy8;
  val_t r2p [8:13];
  val_t xy2p [8:9];
  val_t d1p [8:24];
  val_t ax9, ay9, e2_9;
  val_t r4_13, e4_13;
  val_t d2p [13:24];
  val_t d3p [13:24];
  val_t a1e2p [13:20];
  val_t a2e4p [17:20];
  val_t e6_17, d0_21;
  val_t xd25, yd25, xd26, yd26;
  val_t rv [2];

  // multiplier outputs
  val_t x_raw, y_raw, xx7, yy7, xy7, c1x, c2y;
  val_t r4, b1ax, b2ay, a1e2, b2xy, b1xy;
  val_t r6, a2e4, a3e6, d0x, d0y;

  // pixel to mm
  ldcm_mul #(.SHIFT(PixShift)) u_xr (.clk, .en(adv), .a(px), .b(tx0), .p(x_raw));
  ldcm_mul #(.SHIFT(PixShift)) u_yr (.clk, .en(adv), .a(py), .b(ty0), .p(y_raw));
  // squares, cross term, affine
  ldcm_mul #(.SHIFT(F)) u_xx (.clk, .en(adv), .a(xp[4]), .b(xp[4]), .p(xx7));
  ldcm_mul #(.SHIFT(F)) u_yy (.clk, .en(adv), .a(yp[4]), .b(yp[4]), .p(yy7));
  ldcm_mul #(.SHIFT(F)) u_xy (.clk, .en(adv), .a(xp[4]), .b(yp[4]), .p(xy7));
  ldcm_mul #(.SHIFT(C)) u_c1x (.clk, .en(adv), .a(c1), .b(xp[4]), .p(c1x));
  ldcm_mul #(.SHIFT(C)) u_c2y (.clk, .en(adv), .a(c2), .b(yp[4]), .p(c2y));
  // r4 and decentering, first radial term
  ldcm_mul #(.SHIFT(F)) u_r4 (.clk, .en(adv), .a(r2p[9]), .b(r2p[9]), .p(r4));
  ldcm_mul #(.SHIFT(C)) u_b1ax (.clk, .en(adv), .a(b1), .b(ax9), .p(b1ax));
  ldcm_mul #(.SHIFT(C)) u_b2ay (.clk, .en(adv), .a(b2), .b(ay9), .p(b2ay));
  ldcm_mul #(.SHIFT(C)) u_a1e2 (.clk, .en(adv), .a(a1), .b(e2_9), .p(a1e2));
  ldcm_mul #(.SHIFT(C)) u_b2xy (.clk, .en(adv), .a(b2), .b(xy2p[9]), .p(b2xy));
  ldcm_mul #(.SHIFT(C)) u_b1xy (.clk, .en(adv), .a(b1), .b(xy2p[9]), .p(b1xy));
  // r6 and second radial term
  ldcm_mul #(.SHIFT(F)) u_r6 (.clk, .en(adv), .a(r4_13), .b(r2p[13]), .p(r6));
  ldcm_mul #(.SHIFT(C)) u_a2e4 (.clk, .en(adv), .a(a2), .b(e4_13), .p(a2e4));
  // third radial term
  ldcm_mul #(.SHIFT(C)) u_a3e6 (.clk, .en(adv), .a(a3), .b(e6_17), .p(a3e6));
  // radial scaling of the point
  ldcm_mul #(.SHIFT(F)) u_d0x (.clk, .en(adv), .a(d0_21), .b(xp[21]), .p(d0x));
  ldcm_mul #(.SHIFT(F)) u_d0y (.clk, .en(adv), .a(d0_21), .b(yp[21]), .p(d0y));

  // sums and delay lines
  always_ff @(posedge clk) begin
    if (adv) begin
      // centred doubled pixel offsets, y up
      tx0 <= $signed({35'b0, s_tdata[11:0], 1'b0}) - w_v;
      ty0 <= h_v - $signed({35'b0, s_tdata[23:12], 1'b0});

      // principal offset before the model, applied only when shift_mode is low
      xp[4] <= shift_mode ? x_raw : ldcm_pkg::sat_val(acc_t'(x_raw) + acc_t'(dx));
      yp[4] <= shift_mode ? y_raw : ldcm_pkg::sat_val(acc_t'(y_raw) + acc_t'(dy));
      for (int k = 5; k <= 24; k++) begin
        xp[k] <= xp[k-1];
        yp[k] <= yp[k-1];
      end

      // r2, doubled cross term, affine sum
      xx8    <= xx7;
      yy8    <= yy7;
      r2p[8] <= ldcm_pkg::sat_val(acc_t'(xx7) + acc_t'(yy7));
      for (int k = 9; k <= 13; k++) r2p[k] <= r2p[k-1];
      xy2p[8] <= ldcm_pkg::sat_val(acc_t'(xy7) <<< 1);
      xy2p[9] <= xy2p[8];
      d1p[8]  <= ldcm_pkg::sat_val(acc_t'(c1x) + acc_t'(c2y));
      for (int k = 9; k <= 24; k++) d1p[k] <= d1p[k-1];

      // decentering operands and first radial difference
      ax9  <= ldcm_pkg::sat_val(acc_t'(r2p[8]) + (acc_t'(xx8) <<< 1));
      ay9  <= ldcm_pkg::sat_val(acc_t'(r2p[8]) + (acc_t'(yy8) <<< 1));
      e2_9 <= ldcm_pkg::sat_val(acc_t'(r2p[8]) - acc_t'(q2));

      // second radial difference, decentering sums
      r4_13  <= r4;
      e4_13  <= ldcm_pkg::sat_val(acc_t'(r4) - acc_t'(q4));
      d2p[13] <= ldcm_pkg::sat_val(acc_t'(b1ax) + acc_t'(b2xy));
      d3p[13] <= ldcm_pkg::sat_val(acc_t'(b2ay) + acc_t'(b1xy));
      for (int k = 14; k <= 24; k++) begin
        d2p[k] <= d2p[k-1];
        d3p[k] <= d3p[k-1];
      end
      a1e2p[13] <= a1e2;
      for (int k = 14; k <= 20; k++) a1e2p[k] <= a1e2p[k-1];
      a2e4p[17] <= a2e4;
      for (int k = 18; k <= 20; k++) a2e4p[k] <= a2e4p[k-1];

      // third radial difference and radial factor
      e6_17 <= ldcm_pkg::sat_val(acc_t'(r6) - acc_t'(q6));
      d0_21 <= ldcm_pkg::sat_val(acc_t'(a1e2p[20]) + acc_t'(a2e4p[20]) + acc_t'(a3e6));

      // distorted point
      xd25 <= ldcm_pkg::sat_val(acc_t'(xp[24]) + acc_t'(d0x) + acc_t'(d1p[24])
                                + acc_t'(d2p[24]));
      yd25 <= ldcm_pkg::sat_val(acc_t'(yp[24]) + acc_t'(d0y) + acc_t'(d3p[24]));

      // principal offset after the model
      xd26 <= shift_mode ? ldcm_pkg::sat_val(acc_t'(xd25) + acc_t'(dx))
                         : ldcm_pkg::sat_val(acc_t'(xd25) - acc_t'(dx));
      yd26 <= shift_mode ? ldcm_pkg::sat_val(acc_t'(yd25) + acc_t'(dy))
                         : ldcm_pkg::sat_val(acc_t'(yd25) - acc_t'(dy));

      // back to image origin
      rv[0] <= ldcm_pkg::sat_val(acc_t'(xd26) + acc_t'(x0));
      rv[1] <= ldcm_pkg::sat_val(acc_t'(y0) - acc_t'(yd26));
    end
  end

  // mm to pixels with rounding, one lane per axis
  localparam logic [RndW-1:0] RndHalf = RndW'(1) << (RndShift - 1);

  logic [31:0]     rnd_inv [2];
  logic [W-1:0]    rnd_mag [2];
  logic            r1_neg  [2];
  logic [55:0]     r1_plo  [2];
  logic [55:0]     r1_phi  [2];
  logic            r2_neg  [2];
  logic [RndW-1:0] r2_p    [2];
  logic [RndW-1:0] rnd_q   [2];
  logic [15:0]     rnd_res [2];
  logic [15:0]     res     [2];

  assign rnd_inv[0] = inverse_pitch[31:0];
  assign rnd_inv[1] = inverse_pitch[63:32];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rnd_mag[i] = rv[i][W-1] ? (~rv[i] + 1'b1) : rv[i];
      if (!r2_neg[i]) begin
        rnd_q[i]   = (r2_p[i] + RndHalf) >> RndShift;
        rnd_res[i] = (|rnd_q[i][RndW-1:15]) ? 16'h7FFF : rnd_q[i][15:0];
      end else if (r2_p[i] < RndHalf) begin
        rnd_q[i]   = '0;
        rnd_res[i] = '0;
      end else begin
        rnd_q[i]   = (r2_p[i] - RndHalf) >> RndShift;
        rnd_res[i] = (rnd_q[i] > RndW'(32768)) ? 16'h8000 : (~rnd_q[i][15:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        r1_neg[i] <= rv[i][W-1];
        r1_plo[i] <= rnd_mag[i][W/2-1:0] * rnd_inv[i];
        r1_phi[i] <= rnd_mag[i][W-1:W/2] * rnd_inv[i];
        r2_neg[i] <= r1_neg[i];
        r2_p[i]   <= RndW'(r1_plo[i]) + (RndW'(r1_phi[i]) << (W/2));
        res[i]    <= rnd_res[i];
      end
    end
  end

  // result word
  assign m_tdata = {res[1], res[0]};

endmodule
`default_nettype wire

>>> rtl/core/ldcm_checker.sv
// port-level checker for the lens distortion map, bound to the top level
`default_nettype none
`include "lens_distortion_coordinate_map_top_assert.svh"
module ldcm_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata
);

  // a waiting result word holds until taken
  `LDCM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

  // an empty output register never blocks the input
  `LDCM_ASSERT_NOW(a_in_open, !m_tvalid, s_tready, "input blocked with empty output")

  // reset empties the pipeline
  `LDCM_ASSERT_RST(a_rst_empty, rst, !m_tvalid, "result word right after reset")

endmodule

bind lens_distortion_coordinate_map_top ldcm_checker u_ldcm_checker (.*);
`default_nettype wire
